// ===== src/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with IRQ counter.
// Used by the top level, cbm_regs and cbm_map; depends on nothing.
package cbm_pkg;

  localparam int unsigned OFS_W = 18;

  typedef enum logic [1:0] {
    FUNC_CPU_WR = 2'd0,
    FUNC_CPU_RD = 2'd1,
    FUNC_PPU_RD = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_SWAP_A0_A1   = 2'd0,
    CFG_PRG_ROM_MASK = 2'd1,
    CFG_CHR_ROM_MASK = 2'd2
  } cfg_reg_t;

  // Register decode addresses.
  localparam logic [15:0] REG_PRG16     = 16'h8000;
  localparam logic [15:0] REG_MODE      = 16'hB003;
  localparam logic [15:0] REG_PRG8      = 16'hC000;
  localparam logic [15:0] REG_CHR_LO    = 16'hD000;
  localparam logic [15:0] REG_CHR_HI    = 16'hE000;
  localparam logic [15:0] REG_IRQ_RLD   = 16'hF000;
  localparam logic [15:0] REG_IRQ_CTRL  = 16'hF001;
  localparam logic [15:0] REG_IRQ_ACK   = 16'hF002;

  localparam logic [2:0]  RAM_WINDOW    = 3'b011;   // 0x6000-0x7FFF
  localparam logic [17:0] PRG_FIXED_SUB = 18'h01FFF;
  localparam logic [17:0] OFS_MASK_RST  = 18'h3FFFF;

  localparam logic [9:0]  PRESCALE_RELOAD = 10'd341;
  localparam logic [9:0]  PRESCALE_STEP   = 10'd3;
  localparam logic [9:0]  PRESCALE_WRAP   = PRESCALE_RELOAD - PRESCALE_STEP;
  localparam logic [7:0]  COUNT_LAST      = 8'hFF;

  typedef struct packed {
    func_t       func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic             from_rom;
    logic [OFS_W-1:0] rom_offset;
    logic [7:0]       read_data;
    logic             irq;
    logic [1:0]       mirroring;
  } out_item_t;

  // Banking state seen by the address mapper.
  typedef struct packed {
    logic [3:0]      prg16_bank;
    logic [4:0]      prg8_bank;
    logic [7:0][7:0] chr_bank;
    logic [1:0]      banking_mode;
    logic            ram_enabled;
  } bank_state_t;

  // Mapper answer for one item.
  typedef struct packed {
    logic             from_rom;
    logic [OFS_W-1:0] rom_offset;
    logic             ram_rd;
    logic             ram_we;
  } map_res_t;

endpackage

// ===== src/cartridge_bank_mapper_irq.sv =====
// Top level of the cartridge bank mapper with IRQ counter: pipeline control,
// configuration registers and output register. Depends on cbm_pkg, cbm_regs,
// cbm_map and cbm_wram.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    cbm_pkg::in_item_t
//   out_     output     out_valid / out_ready  cbm_pkg::out_item_t
//   cfg_     input      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an item's result
// passes from its transfer in through the input register, then decode and
// mapping into the result register and the work RAM read register.
// Mapper state updates at the end of the decode cycle, so the next item sees it.
// Reset clears all mapper and IRQ state; work RAM contents are kept.
// A stalled output holds the decode stage, which in turn holds the input.
module cartridge_bank_mapper_irq #(
  parameter int unsigned WORK_RAM_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cbm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cbm_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [17:0]         cfg_data
);
  import cbm_pkg::*;

  localparam int unsigned RAM_AW = $clog2(WORK_RAM_BYTES);

  logic        swap_r;
  logic [17:0] prg_mask_r;
  logic [17:0] chr_mask_r;

  logic        s1_v_r;
  in_item_t    s1_item_r;
  logic        out_v_r;
  logic        from_rom_r;
  logic [17:0] ofs_r;
  logic        irq_r;
  logic [1:0]  mirror_r;
  logic        ram_sel_r;

  logic        adv;
  bank_state_t bank;
  logic        irq_nxt;
  logic [1:0]  mirror_nxt;
  map_res_t    res;
  logic [7:0]  ram_q;

  // The decode stage moves on whenever the result register is free or draining.
  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r     <= 1'b0;
      prg_mask_r <= OFS_MASK_RST;
      chr_mask_r <= OFS_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWAP_A0_A1:   swap_r     <= cfg_data[0];
        CFG_PRG_ROM_MASK: prg_mask_r <= cfg_data;
        CFG_CHR_ROM_MASK: chr_mask_r <= cfg_data;
        default:          swap_r     <= swap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      from_rom_r <= res.from_rom;
      ofs_r      <= res.rom_offset;
      irq_r      <= irq_nxt;
      mirror_r   <= mirror_nxt;
      ram_sel_r  <= res.ram_rd;
    end
  end

  cbm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (s1_item_r),
    .swap_a0_a1 (swap_r),
    .bank       (bank),
    .irq_nxt    (irq_nxt),
    .mirror_nxt (mirror_nxt)
  );

  cbm_map u_map (
    .item         (s1_item_r),
    .bank         (bank),
    .prg_rom_mask (prg_mask_r),
    .chr_rom_mask (chr_mask_r),
    .res          (res)
  );

  cbm_wram #(
    .DEPTH (WORK_RAM_BYTES)
  ) u_wram (
    .clk   (clk),
    .we    (adv && res.ram_we),
    .re    (adv && res.ram_rd),
    .addr  (s1_item_r.address[RAM_AW-1:0]),
    .wdata (s1_item_r.write_data),
    .rdata (ram_q)
  );

  assign out_valid           = out_v_r;
  assign out_data.from_rom   = from_rom_r;
  assign out_data.rom_offset = ofs_r;
  assign out_data.read_data  = ram_sel_r ? ram_q : 8'd0;
  assign out_data.irq        = irq_r;
  assign out_data.mirroring  = mirror_r;

endmodule

// ===== src/cbm_wram.sv =====
// Work RAM: single-port byte memory with a registered read port.
// Depends on nothing; instantiated by the top level.
module cbm_wram #(
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      q_r <= mem_r[addr];
    end
  end

  assign rdata = q_r;

endmodule

// ===== src/cbm_regs.sv =====
// Mapper register file and scanline/cycle IRQ counter.
// Depends on cbm_pkg; instantiated by the top level.
module cbm_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  cbm_pkg::in_item_t   item,
  input  logic                swap_a0_a1,
  output cbm_pkg::bank_state_t bank,
  output logic                irq_nxt,
  output logic [1:0]          mirror_nxt
);
  import cbm_pkg::*;

  logic [3:0]      prg16_r, prg16_nxt;
  logic [4:0]      prg8_r, prg8_nxt;
  logic [7:0][7:0] chr_r, chr_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [1:0]      mirror_r;
  logic            ram_en_r, ram_en_nxt;
  logic [7:0]      reload_r, reload_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [9:0]      prescale_r, prescale_nxt;
  logic            armed_r, armed_nxt;
  logic            rearm_r, rearm_nxt;
  logic            cycle_r, cycle_nxt;
  logic            pending_r;

  logic [15:0] t;
  logic        is_ram;
  logic        do_step;
  logic [7:0]  d;

  // Register decode sees A0 and A1 swapped on the variant board.
  assign t      = swap_a0_a1 ? {item.address[15:2], item.address[0], item.address[1]}
                             : item.address;
  assign is_ram = (item.address[15:13] == RAM_WINDOW);
  assign d      = item.write_data;

  always_comb begin
    prg16_nxt    = prg16_r;
    prg8_nxt     = prg8_r;
    chr_nxt      = chr_r;
    mode_nxt     = mode_r;
    mirror_nxt   = mirror_r;
    ram_en_nxt   = ram_en_r;
    reload_nxt   = reload_r;
    count_nxt    = count_r;
    prescale_nxt = prescale_r;
    armed_nxt    = armed_r;
    rearm_nxt    = rearm_r;
    cycle_nxt    = cycle_r;
    irq_nxt      = pending_r;
    do_step      = 1'b0;

    if (item.func == FUNC_CPU_WR && !is_ram) begin
      if (t[15:2] == REG_PRG16[15:2]) begin
        prg16_nxt = d[3:0];
      end else if (t[15:2] == REG_PRG8[15:2]) begin
        prg8_nxt = d[4:0];
      end else if (t == REG_MODE) begin
        mode_nxt   = d[1:0];
        mirror_nxt = d[3:2];
        ram_en_nxt = d[7];
      end else if (t[15:2] == REG_CHR_LO[15:2]) begin
        chr_nxt[{1'b0, t[1:0]}] = d;
      end else if (t[15:2] == REG_CHR_HI[15:2]) begin
        chr_nxt[{1'b1, t[1:0]}] = d;
      end else if (t == REG_IRQ_RLD) begin
        reload_nxt = d;
      end else if (t == REG_IRQ_CTRL) begin
        irq_nxt      = 1'b0;
        rearm_nxt    = d[0];
        armed_nxt    = d[1];
        cycle_nxt    = d[2];
        count_nxt    = reload_r;
        prescale_nxt = PRESCALE_RELOAD;
      end else if (t == REG_IRQ_ACK) begin
        irq_nxt   = 1'b0;
        armed_nxt = rearm_r;
      end
    end else if (item.func == FUNC_TICK && armed_r) begin
      if (cycle_r) begin
        do_step = 1'b1;
      end else if (prescale_r <= PRESCALE_STEP) begin
        prescale_nxt = prescale_r + PRESCALE_WRAP;
        do_step      = 1'b1;
      end else begin
        prescale_nxt = prescale_r - PRESCALE_STEP;
      end
    end

    if (do_step) begin
      if (count_r == COUNT_LAST) begin
        irq_nxt   = 1'b1;
        count_nxt = reload_r;
      end else begin
        count_nxt = count_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg16_r    <= '0;
      prg8_r     <= '0;
      chr_r      <= '0;
      mode_r     <= '0;
      mirror_r   <= '0;
      ram_en_r   <= 1'b0;
      reload_r   <= '0;
      count_r    <= '0;
      prescale_r <= '0;
      armed_r    <= 1'b0;
      rearm_r    <= 1'b0;
      cycle_r    <= 1'b0;
      pending_r  <= 1'b0;
    end else if (adv) begin
      prg16_r    <= prg16_nxt;
      prg8_r     <= prg8_nxt;
      chr_r      <= chr_nxt;
      mode_r     <= mode_nxt;
      mirror_r   <= mirror_nxt;
      ram_en_r   <= ram_en_nxt;
      reload_r   <= reload_nxt;
      count_r    <= count_nxt;
      prescale_r <= prescale_nxt;
      armed_r    <= armed_nxt;
      rearm_r    <= rearm_nxt;
      cycle_r    <= cycle_nxt;
      pending_r  <= irq_nxt;
    end
  end

  assign bank.prg16_bank   = prg16_r;
  assign bank.prg8_bank    = prg8_r;
  assign bank.chr_bank     = chr_r;
  assign bank.banking_mode = mode_r;
  assign bank.ram_enabled  = ram_en_r;

endmodule

// ===== src/cbm_map.sv =====
// Address mapper: turns a read into a PRG/CHR ROM offset or a work RAM read, and a write into a work RAM write.
// Depends on cbm_pkg; instantiated by the top level.
module cbm_map (
  input  cbm_pkg::in_item_t    item,
  input  cbm_pkg::bank_state_t bank,
  input  logic [17:0]          prg_rom_mask,
  input  logic [17:0]          chr_rom_mask,
  output cbm_pkg::map_res_t    res
);
  import cbm_pkg::*;

  logic [15:0] a;
  logic        is_ram;
  logic [2:0]  slot;
  logic [2:0]  chr_idx;
  logic [7:0]  chr_sel;

  assign a      = item.address;
  assign is_ram = (a[15:13] == RAM_WINDOW);
  assign slot   = a[12:10];

  always_comb begin
    unique case (bank.banking_mode)
      2'd0:    chr_idx = slot;
      2'd1:    chr_idx = {1'b0, slot[2:1]};
      default: chr_idx = slot[2] ? {2'b10, slot[1]} : slot;
    endcase
  end

  assign chr_sel = bank.chr_bank[chr_idx];

  always_comb begin
    res.from_rom   = 1'b0;
    res.rom_offset = '0;
    res.ram_rd     = 1'b0;
    res.ram_we     = 1'b0;

    unique case (item.func)
      FUNC_CPU_WR: begin
        res.ram_we = is_ram && bank.ram_enabled;
      end
      FUNC_CPU_RD: begin
        if (is_ram) begin
          res.ram_rd = bank.ram_enabled;
        end else if (a[15:14] == 2'b10) begin
          res.from_rom   = 1'b1;
          res.rom_offset = ({bank.prg16_bank, 14'd0} & prg_rom_mask) + {4'd0, a[13:0]};
        end else if (a[15:13] == 3'b110) begin
          res.from_rom   = 1'b1;
          res.rom_offset = ({bank.prg8_bank, 13'd0} & prg_rom_mask) + {5'd0, a[12:0]};
        end else if (a[15:13] == 3'b111) begin
          // Last 8 KB is fixed to the end of program ROM.
          res.from_rom   = 1'b1;
          res.rom_offset = prg_rom_mask - PRG_FIXED_SUB + {5'd0, a[12:0]};
        end
      end
      FUNC_PPU_RD: begin
        res.from_rom   = 1'b1;
        res.rom_offset = ({chr_sel, 10'd0} & chr_rom_mask) + {8'd0, a[9:0]};
      end
      FUNC_TICK: begin
        res.from_rom = 1'b0;
      end
    endcase
  end

endmodule
